FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bdam_pkg.sv
// Constants and character classes for the device address masker.
package bdam_pkg;

	localparam int WinDepth  = 18;
	localparam int AddrLen   = 17;
	localparam int MaskFirst = 9;
	localparam int MaskCount = 8;
	localparam int FillW     = $clog2(WinDepth + 1);

	localparam logic [7:0] Colon    = 8'h3a;
	localparam logic [7:0] MaskChar = 8'h78;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic is_part(input logic [7:0] c);
		return (c == Colon) || is_hex(c);
	endfunction

endpackage

FILE: rtl/core/bd_address_masker.sv
// Device address masker: 18-byte window that masks the tail of each address.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_stall, in_char, in_last   | into block
//  out     | out_valid, out_stall, out_char, out_last| out of block
//
// One item a cycle in and out once the window holds 18 bytes and out_stall
// is low; the window shift register and the output register set that rate.
// After an item with in_last the window drains one item a cycle while
// out_stall is low, with in_stall high; the block then starts a new text.
// arst_n clears fill count, marks, drain flag and output valid.
// A stalled output holds the window and stalls the input when it is full.
module bd_address_masker
	import bdam_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_last
);

	logic [7:0]       win_q  [WinDepth];
	logic [7:0]       win_n  [WinDepth];
	logic             mark_q [WinDepth];
	logic             mark_n [WinDepth];
	logic [FillW-1:0] fill_q, fill_n;
	logic             drain_q;
	logic             prev_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	logic             out_free;
	logic             emit;
	logic             accept;
	logic             test_en;
	logic             have_next;
	logic [AddrLen-1:0] pos_ok;
	logic             hit;
	logic [FillW-1:0] wr_idx;
	logic [7:0]       head_char;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = out_free && (drain_q ? (fill_q != '0) :
		(fill_q == FillW'(WinDepth)));
	assign in_stall  = drain_q || ((fill_q == FillW'(WinDepth)) && !emit);
	assign accept    = in_valid && !in_stall;
	assign have_next = (fill_q == FillW'(WinDepth));
	assign test_en   = emit && (have_next || (drain_q && (fill_q == FillW'(AddrLen))));

	always_comb begin
		for (int k = 0; k < AddrLen; k++) begin
			if ((k % 3) == 2) begin
				pos_ok[k] = (win_q[k] == Colon);
			end else begin
				pos_ok[k] = is_hex(win_q[k]);
			end
		end
	end

	assign hit = test_en && (&pos_ok) && !prev_q &&
		!(have_next && is_part(win_q[AddrLen]));

	assign head_char = mark_q[0] ? ((win_q[0] == Colon) ? Colon : MaskChar) : win_q[0];
	assign wr_idx    = emit ? FillW'(WinDepth - 1) : fill_q;

	always_comb begin
		win_n  = win_q;
		mark_n = mark_q;
		fill_n = fill_q;
		if (emit) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_n[i]  = win_q[i+1];
				mark_n[i] = mark_q[i+1] ||
					(hit && (i >= MaskFirst - 1) && (i <= MaskFirst + MaskCount - 2));
			end
			mark_n[WinDepth-1] = 1'b0;
			fill_n = fill_q - FillW'(1);
		end
		if (accept) begin
			win_n[wr_idx]  = in_char;
			mark_n[wr_idx] = 1'b0;
			fill_n = fill_n + FillW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_q     <= 1'b0;
			prev_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WinDepth; i++) begin
				mark_q[i] <= 1'b0;
			end
		end else begin
			fill_q <= fill_n;
			mark_q <= mark_n;
			if (accept && in_last) begin
				drain_q <= 1'b1;
			end else if (emit && drain_q && (fill_q == FillW'(1))) begin
				drain_q <= 1'b0;
			end
			if (emit) begin
				prev_q <= (drain_q && (fill_q == FillW'(1))) ? 1'b0 : is_part(win_q[0]);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
		if (emit) begin
			out_char_q <= head_char;
			out_last_q <= drain_q && (fill_q == FillW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

FILE: rtl/core/bdam_checker.sv
// Port checker for the device address masker, bound to bd_address_masker.
`include "assert_macros.svh"

module bdam_checker
	import bdam_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_char,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       out_last
);

	logic in_take;
	logic in_end;

	assign in_take = in_valid && !in_stall;
	assign in_end  = in_take && in_last && (in_char == in_char);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "output item dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_char) && $stable(out_last), "stalled output item changed")
	`ASSERT_NEXT(a_drain_stall, clk, arst_n, in_end, in_stall, "input taken during drain")
	`ASSERT_NEXT(a_drain_emit, clk, arst_n, in_stall && !out_valid, out_valid && (out_char == out_char) && (MaskChar != Colon), "drain cycle without output item")

endmodule

bind bd_address_masker bdam_checker u_bdam_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_char   (in_char),
	.in_last   (in_last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.out_last  (out_last)
);
